@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/adsr_pkg.sv @@
package adsr_pkg;

    // Fixed widths
    localparam int LEVEL_W    = 16;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 15;
    localparam int CNT_W      = COUNT_BITS + 1;
    localparam int PROD_W     = LEVEL_W + COUNT_BITS;
    localparam int DIV_STEPS  = LEVEL_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Level constants, unsigned Q1.15
    localparam logic [LEVEL_W-1:0] ONE_LEVEL  = LEVEL_W'(1) << FRAC_BITS;
    localparam logic [LEVEL_W-1:0] ZERO_LEVEL = '0;

    // Register reset values
    localparam logic [COUNT_BITS-1:0] RST_ATTACK  = COUNT_BITS'(480);
    localparam logic [COUNT_BITS-1:0] RST_DECAY   = COUNT_BITS'(4800);
    localparam logic [LEVEL_W-1:0]    RST_SUSTAIN = LEVEL_W'(16384);
    localparam logic [COUNT_BITS-1:0] RST_RELEASE = COUNT_BITS'(4800);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_DECAY   = 2'd1,
        CFG_SUSTAIN = 2'd2,
        CFG_RELEASE = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    // Configuration register set
    typedef struct packed {
        logic [COUNT_BITS-1:0] attack_len;
        logic [COUNT_BITS-1:0] decay_len;
        logic [LEVEL_W-1:0]    sustain;
        logic [COUNT_BITS-1:0] release_len;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic wb;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic direct;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/adsr_cfg.sv @@
module adsr_cfg
    import adsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file, one write per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_len  <= RST_ATTACK;
            r_cfg.decay_len   <= RST_DECAY;
            r_cfg.sustain     <= RST_SUSTAIN;
            r_cfg.release_len <= RST_RELEASE;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ATTACK:  r_cfg.attack_len  <= i_cfg_data[COUNT_BITS-1:0];
                CFG_DECAY:   r_cfg.decay_len   <= i_cfg_data[COUNT_BITS-1:0];
                CFG_SUSTAIN: r_cfg.sustain     <= i_cfg_data[LEVEL_W-1:0];
                CFG_RELEASE: r_cfg.release_len <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/adsr_dp.sv @@
module adsr_dp
    import adsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_gate,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LEVEL_W-1:0] o_level
);

    `include "assert_macros.svh"

    // Envelope state
    t_phase                r_phase;
    logic [CNT_W-1:0]      r_count;
    logic [LEVEL_W-1:0]    r_start;
    logic [LEVEL_W-1:0]    r_last;
    logic                  r_gate;

    // Per-sample working registers
    logic [LEVEL_W-1:0]    r_target;
    logic [COUNT_BITS-1:0] r_len;
    logic [LEVEL_W-1:0]    r_mag;
    logic                  r_up;
    logic                  r_ramp;
    logic                  r_direct;
    t_phase                r_next_phase;
    logic [LEVEL_W-1:0]    r_next_start;
    logic [COUNT_BITS-1:0] r_rem;
    logic [LEVEL_W-1:0]    r_lo;

    // Output register
    logic                  r_out_valid;
    logic [LEVEL_W-1:0]    r_level;

    // Load-time decode
    logic                  rise;
    logic                  fall;
    t_phase                eff_phase;
    logic [CNT_W-1:0]      eff_count;
    logic [LEVEL_W-1:0]    eff_start;
    logic [LEVEL_W-1:0]    sus_sat;
    logic [LEVEL_W-1:0]    tgt;
    logic [COUNT_BITS-1:0] len;
    t_phase                nxt_phase;
    logic [LEVEL_W-1:0]    nxt_start;
    logic                  ramp;
    logic                  up;
    logic [LEVEL_W-1:0]    mag;
    logic                  direct;

    // Arithmetic
    logic [PROD_W-1:0]     prod;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  q_bit;
    logic [LEVEL_W-1:0]    v;
    logic [CNT_W-1:0]      count_inc;

    // Edge detect and phase selection for the incoming gate sample
    always_comb begin
        rise      = !r_gate && i_gate;
        fall      = r_gate && !i_gate;
        eff_phase = rise ? PH_ATTACK : (fall ? PH_RELEASE : r_phase);
        eff_count = (rise || fall) ? '0 : r_count;
        eff_start = (rise || fall) ? r_last : r_start;
        sus_sat   = (i_cfg.sustain > ONE_LEVEL) ? ONE_LEVEL : i_cfg.sustain;
        tgt       = ZERO_LEVEL;
        len       = '0;
        nxt_phase = PH_OFF;
        nxt_start = eff_start;
        ramp      = 1'b0;
        unique case (eff_phase)
            PH_ATTACK: begin
                tgt       = ONE_LEVEL;
                len       = i_cfg.attack_len;
                nxt_phase = PH_DECAY;
                nxt_start = ONE_LEVEL;
                ramp      = 1'b1;
            end
            PH_DECAY: begin
                tgt       = sus_sat;
                len       = i_cfg.decay_len;
                nxt_phase = PH_SUSTAIN;
                nxt_start = sus_sat;
                ramp      = 1'b1;
            end
            PH_SUSTAIN: begin
                tgt       = sus_sat;
                nxt_phase = PH_SUSTAIN;
            end
            PH_RELEASE: begin
                tgt       = ZERO_LEVEL;
                len       = i_cfg.release_len;
                nxt_phase = PH_OFF;
                ramp      = 1'b1;
            end
            default: begin
                tgt       = ZERO_LEVEL;
                nxt_phase = PH_OFF;
            end
        endcase
        up     = (tgt >= eff_start);
        mag    = up ? (tgt - eff_start) : (eff_start - tgt);
        direct = !ramp || (len == '0) || (eff_count >= {1'b0, len});
    end

    // Multiply, divide step and write-back value
    always_comb begin
        prod      = PROD_W'(r_mag) * PROD_W'(r_count[COUNT_BITS-1:0]);
        rem_sh    = {r_rem, r_lo[LEVEL_W-1]};
        q_bit     = (rem_sh >= {1'b0, r_len});
        v         = r_direct ? r_target : (r_up ? (r_start + r_lo) : (r_start - r_lo));
        count_inc = r_count + CNT_W'(1);
    end

    // Envelope state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OFF;
            r_count     <= '0;
            r_start     <= '0;
            r_last      <= '0;
            r_gate      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_phase <= ramp ? eff_phase : nxt_phase;
                r_count <= eff_count;
                r_start <= eff_start;
                r_gate  <= i_gate;
            end
            if (i_cmd.wb) begin
                r_level     <= v;
                r_out_valid <= 1'b1;
                if (r_ramp) begin
                    r_last <= v;
                    if (count_inc > {1'b0, r_len}) begin
                        r_phase <= r_next_phase;
                        r_count <= '0;
                        r_start <= r_next_start;
                    end else begin
                        r_count <= count_inc;
                    end
                end else if (r_phase == PH_SUSTAIN) begin
                    r_last <= v;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers: operand capture, product, restoring divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target     <= tgt;
            r_len        <= len;
            r_mag        <= mag;
            r_up         <= up;
            r_ramp       <= ramp;
            r_direct     <= direct;
            r_next_phase <= nxt_phase;
            r_next_start <= nxt_start;
        end
        if (i_cmd.mul) begin
            r_rem <= prod[PROD_W-1:LEVEL_W];
            r_lo  <= prod[LEVEL_W-1:0];
        end
        if (i_cmd.div) begin
            r_rem <= q_bit ? COUNT_BITS'(rem_sh - {1'b0, r_len}) : rem_sh[COUNT_BITS-1:0];
            r_lo  <= {r_lo[LEVEL_W-2:0], q_bit};
        end
    end

    assign o_status.direct   = r_direct;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_level           = r_level;

    `ASSERT_IMPLIES(a_level_range, r_out_valid, r_level <= ONE_LEVEL, "level above 1.0")
    `ASSERT_IMPLIES(a_step_bounded, i_cmd.wb && !r_direct, r_lo <= r_mag,
        "ramp step exceeds ramp span")
    `ASSERT_IMPLIES(a_wb_slot_free, i_cmd.wb, !r_out_valid || i_out_ready,
        "result overwrites an untaken level")

endmodule

@@ rtl/core/adsr_ctrl.sv @@
module adsr_ctrl
    import adsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_WB
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;

    // Command decode
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul  = (r_state == S_MUL) && !i_status.direct;
        o_cmd.div  = (r_state == S_DIV);
        o_cmd.wb   = (r_state == S_WB) && i_status.out_free;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step  <= '0;
                    r_state <= i_status.direct ? S_WB : S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_cmd_onehot, $onehot0({o_cmd.load, o_cmd.mul, o_cmd.div, o_cmd.wb}),
        "more than one datapath command")
    `ASSERT_IMPLIES(a_div_runs, o_cmd.div && (r_step != STEP_W'(DIV_STEPS - 1)),
        ##1 o_cmd.div, "divide sequence cut short")

endmodule

@@ rtl/core/adsr_envelope_generator_unit.sv @@
// Linear ADSR envelope: one gate sample per transaction in, one unsigned Q1.15 level
// (32768 = 1.0) per transaction out. Rising gate starts attack from the last level,
// falling gate starts release from the last level. A sample whose ramp needs
// interpolation goes through one 16x16 multiply, 16 restoring-divide steps at one
// quotient bit per cycle, and write-back; held, off, and ramp-end samples skip the
// multiply and divide. The next sample is taken once write-back is done and the
// sequencer is idle again, so one sample is processed at a time and the divider
// sets the rate. A finished level sits in an output register, so the next gate
// sample is accepted while it waits; write-back of the following level stalls until
// that register is taken. Configuration writes are taken any cycle and must only be
// issued while the unit is idle.
module adsr_envelope_generator_unit
    import adsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_gate,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LEVEL_W-1:0]    o_level
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    adsr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    adsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    adsr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_gate      (i_gate),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_level     (o_level)
    );

endmodule

@@ tb/sv/tb_adsr_envelope_generator_unit.sv @@
module tb_adsr_envelope_generator_unit;
    import adsr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_GATES  = 100;

    // Envelope predictor and expected-level store
    class envelope_scoreboard;
        logic [COUNT_BITS-1:0] attack_len;
        logic [COUNT_BITS-1:0] decay_len;
        logic [LEVEL_W-1:0]    sustain;
        logic [COUNT_BITS-1:0] release_len;
        t_phase                phase;
        logic [CNT_W-1:0]      ramp_count;
        logic [LEVEL_W-1:0]    ramp_start;
        logic [LEVEL_W-1:0]    last_level;
        logic                  last_gate;
        logic [LEVEL_W-1:0]    expected_levels[$];
        int                    errors;

        function new();
            attack_len  = RST_ATTACK;
            decay_len   = RST_DECAY;
            sustain     = RST_SUSTAIN;
            release_len = RST_RELEASE;
            phase       = PH_OFF;
            ramp_count  = '0;
            ramp_start  = ZERO_LEVEL;
            last_level  = ZERO_LEVEL;
            last_gate   = 1'b0;
            errors      = 0;
        endfunction

        function void note_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ATTACK:  attack_len  = data;
                CFG_DECAY:   decay_len   = data;
                CFG_SUSTAIN: sustain     = data;
                CFG_RELEASE: release_len = data;
                default: ;
            endcase
        endfunction

        // Sustain register clipped to full scale
        function logic [LEVEL_W-1:0] held_sustain();
            return (sustain > ONE_LEVEL) ? ONE_LEVEL : sustain;
        endfunction

        // Linear point between ramp start and target, step truncated
        function logic [LEVEL_W-1:0] interpolate(logic [LEVEL_W-1:0] target,
                                                 logic [COUNT_BITS-1:0] len);
            longint unsigned span;
            longint unsigned step;
            if (len == 0 || ramp_count >= len)
                return target;
            span = (target >= ramp_start) ? target - ramp_start : ramp_start - target;
            step = (span * ramp_count) / len;
            return LEVEL_W'((target >= ramp_start) ? ramp_start + step : ramp_start - step);
        endfunction

        // One ramp sample; moves to the next phase after len+1 samples
        function logic [LEVEL_W-1:0] ramp(logic [LEVEL_W-1:0] target,
                                          logic [COUNT_BITS-1:0] len,
                                          t_phase next_phase,
                                          logic [LEVEL_W-1:0] next_start);
            logic [LEVEL_W-1:0] lvl;
            lvl = interpolate(target, len);
            last_level = lvl;
            ramp_count = ramp_count + CNT_W'(1);
            if (ramp_count > len) begin
                phase      = next_phase;
                ramp_count = '0;
                ramp_start = next_start;
            end
            return lvl;
        endfunction

        function void note_gate(logic gate);
            logic [LEVEL_W-1:0] lvl;
            // gate edges restart a ramp from the last level
            if (!last_gate && gate) begin
                phase      = PH_ATTACK;
                ramp_count = '0;
                ramp_start = last_level;
            end else if (last_gate && !gate) begin
                phase      = PH_RELEASE;
                ramp_count = '0;
                ramp_start = last_level;
            end
            case (phase)
                PH_ATTACK:  lvl = ramp(ONE_LEVEL, attack_len, PH_DECAY, ONE_LEVEL);
                PH_DECAY:   lvl = ramp(held_sustain(), decay_len, PH_SUSTAIN, held_sustain());
                PH_SUSTAIN: begin
                    lvl = held_sustain();
                    last_level = lvl;
                end
                PH_RELEASE: lvl = ramp(ZERO_LEVEL, release_len, PH_OFF, ramp_start);
                default: begin
                    phase = PH_OFF;
                    lvl   = ZERO_LEVEL;
                end
            endcase
            last_gate = gate;
            expected_levels.push_back(lvl);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_level(logic [LEVEL_W-1:0] got);
            logic [LEVEL_W-1:0] want;
            if (expected_levels.size() == 0) begin
                report($sformatf("level %0d arrived with nothing pending", got));
                return;
            end
            want = expected_levels.pop_front();
            if (got !== want)
                report($sformatf("level %0d, predicted %0d", got, want));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ATTACK;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_gate = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [LEVEL_W-1:0]    o_level;

    envelope_scoreboard sb = new();
    bit                 steady = 1'b0;
    int                 gates_sent = 0;
    int                 stall_cycles = 0;

    adsr_envelope_generator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_gate      (i_gate),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_level     (o_level)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Level sink: check each transaction, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_level(o_level);
        i_out_ready <= steady || ($urandom_range(99) >= 17);
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_gate(input logic gate);
        if (!steady && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_gate     <= gate;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_gate(gate);
        gates_sent++;
    endtask

    task automatic send_run(input logic gate, input int count);
        repeat (count) send_gate(gate);
    endtask

    // Leaves valid high so back-to-back writes stay contiguous
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_register(idx, data);
    endtask

    task automatic write_all(input logic [15:0] atk, input logic [15:0] dec,
                             input logic [15:0] sus, input logic [15:0] rel);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_DECAY, dec);
        write_reg(CFG_SUSTAIN, sus);
        write_reg(CFG_RELEASE, rel);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait for every pending level
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_levels.size() != 0);
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'd0;
        if (r < 18) return 16'hFFFF;
        if (r < 25) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(1, 24));
    endfunction

    function automatic logic [15:0] pick_sustain();
        int r;
        r = $urandom_range(99);
        if (r < 15) return ONE_LEVEL;
        if (r < 25) return ZERO_LEVEL;
        if (r < 40) return 16'($urandom_range(32769, 65535));
        return 16'($urandom_range(0, 32768));
    endfunction

    initial begin
        logic [15:0] atk, dec, sus, rel;
        int          hi, lo, target;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: off output, attack start, release during attack
        send_gate(1'b0);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        drain();

        // Zero-length ramps with sustain above full scale
        write_all(16'd0, 16'd0, 16'hFFFF, 16'd0);
        send_run(1'b1, 3);
        send_run(1'b0, 3);
        drain();

        // Stop partway into decay, then change sustain mid-ramp
        write_all(16'd2, 16'd4, 16'd20000, 16'hFFFF);
        send_run(1'b1, 5);
        drain();
        write_reg(CFG_SUSTAIN, ZERO_LEVEL);
        i_cfg_valid <= 1'b0;
        send_run(1'b1, 3);
        send_gate(1'b0);
        drain();

        // Longest ramps, shortest nonzero release
        write_all(16'hFFFF, 16'hFFFF, ONE_LEVEL, 16'd1);
        send_run(1'b1, 2);
        send_run(1'b0, 3);
        drain();

        // Random settings; mostly whole notes sized to the ramps, some noise
        for (int p = 0; p < RAND_PHASES; p++) begin
            steady = (p == 4);
            atk = pick_length();
            dec = pick_length();
            sus = pick_sustain();
            rel = pick_length();
            write_all(atk, dec, sus, rel);
            target = gates_sent + PHASE_GATES;
            while (gates_sent < target) begin
                if ($urandom_range(99) < 80) begin
                    hi = int'(atk) + int'(dec) + 8;
                    lo = int'(rel) + 6;
                    if (hi > 80) hi = 80;
                    if (lo > 60) lo = 60;
                    send_run(1'b1, $urandom_range(1, hi));
                    send_run(1'b0, $urandom_range(1, lo));
                end else begin
                    send_gate(1'($urandom_range(0, 1)));
                end
            end
            drain();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
